// File: rtl/frequency_to_fnum_block_macros.svh
// Assertion macros shared by the frequency to fnum checker.
`ifndef FREQUENCY_TO_FNUM_BLOCK_MACROS_SVH
`define FREQUENCY_TO_FNUM_BLOCK_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FTFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frequency_to_fnum_block assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define FTFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frequency_to_fnum_block assertion failed");

// Next-cycle implication that is also checked across reset.
`define FTFB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frequency_to_fnum_block assertion failed");

`endif

// File: rtl/ftfb_pkg.sv
// Shared constants, types and functions of the frequency to fnum converter.
package ftfb_pkg;

    localparam int MILLI_W    = 32;
    localparam int FACTOR_W   = 16;
    localparam int FNUM_W     = 10;
    localparam int BLOCK_W    = 3;
    localparam int SCALE_W    = 10;
    localparam int MHZ_W      = 23;
    localparam int D_W        = 26;
    localparam int D2_W       = D_W + 1;
    localparam int NUM_W      = 45;
    localparam int REM_W      = 37;
    localparam int LIM_SHIFT  = FNUM_W + 1;
    localparam int SH_W       = 5;

    localparam int FRONT_STAGES = 3;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_STAGES   = FNUM_W / DIV_STEPS;
    localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd49716;
    localparam logic [MILLI_W-1:0]  TOP_MHZ      = 32'd6208431;
    localparam logic [SCALE_W-1:0]  D_SCALE      = 10'd1000;
    localparam logic [FNUM_W-1:0]   FNUM_MAX     = 10'd1023;
    localparam logic [BLOCK_W-1:0]  BLOCK_MAX    = 3'd7;
    localparam logic [SH_W-1:0]     SHIFT_BASE   = 5'd21;

    localparam logic [MILLI_W-1:0] BLOCK_FLOOR [7] = '{
        32'd3104215, 32'd1552107, 32'd776053, 32'd388026,
        32'd194013, 32'd97006, 32'd48503
    };

    typedef struct packed {
        logic zero;
        logic fsat;
    } t_flags;

    typedef struct packed {
        logic             qbit;
        logic [REM_W-1:0] rem;
    } t_step;

    // Highest octave block whose floor the frequency exceeds.
    function automatic logic [BLOCK_W-1:0] pick_block(input logic [MILLI_W-1:0] m);
        logic [BLOCK_W-1:0] b;
        b = '0;
        for (int i = 6; i >= 0; i--) begin
            if (m > BLOCK_FLOOR[i]) begin
                b = BLOCK_MAX - BLOCK_W'(i);
            end
        end
        return b;
    endfunction

    // One restoring division step against an already shifted divisor.
    function automatic t_step div_step(input logic [REM_W-1:0] rem,
                                       input logic [REM_W-1:0] dsh);
        t_step s;
        if (rem >= dsh) begin
            s.qbit = 1'b1;
            s.rem  = rem - dsh;
        end else begin
            s.qbit = 1'b0;
            s.rem  = rem;
        end
        return s;
    endfunction

endpackage

// File: rtl/frequency_to_fnum_block.sv
// Frequency to fnum/block converter: a fully pipelined millihertz to OPL pitch translator.
//
// This block turns a note frequency in millihertz into the 10-bit frequency number and
// 3-bit octave block of an OPL-style FM chip. Zero gives block 0, fnum 0; anything above
// 6208431 mHz, or a conversion factor of zero, gives block 7, fnum 1023. Otherwise a
// chain of thresholds picks the block and fnum is m*2^(20-block)/(1000*factor) rounded
// half up; when that fnum does not fit in 10 bits the block is raised once, and if the
// block is already 7 the result saturates to block 7, fnum 1023. The block is an
// eight-stage pipeline: the first stage picks the block and forms the divisor with one
// 16x10 multiply, the second builds both candidate numerators, the third chooses the
// block and catches saturation, and five stages then each retire two quotient bits of a
// restoring divider. One request is taken every clock unless every stage is full and
// the output side is stalled; results pass through the stages in order. Each stage holds
// its data only while it is full and blocked, so bubbles collapse and a stalled result
// does not stop new requests from entering until every stage is occupied. The
// conversion factor register resets to 49716 and should only be written while the
// pipeline is empty; its write channel is always ready.
module frequency_to_fnum_block
    import ftfb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [FACTOR_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MILLI_W-1:0]  i_milli_hertz,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [FNUM_W-1:0]   o_fnum_out,
    output logic [BLOCK_W-1:0]  o_block_out
);

    localparam int LAST = N_STAGES - 1;

    // Configuration register.
    logic [FACTOR_W-1:0] r_factor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (i_cfg_valid) begin
            r_factor <= i_cfg_data;
        end
    end

    // Per-stage valid bits and load enables. A stage loads when it is empty
    // or when the stage after it is moving.
    logic r_v [N_STAGES];
    logic en  [N_STAGES];

    always_comb begin
        en[LAST] = !r_v[LAST] || i_out_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i + 1];
        end
    end

    assign o_in_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_STAGES; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int i = 1; i < N_STAGES; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i - 1];
                end
            end
        end
    end

    // Stage A: classify the frequency, pick the block, form the divisor.
    logic [MHZ_W-1:0]   r_a_mhz;
    logic [BLOCK_W-1:0] r_a_blk;
    logic [D_W-1:0]     r_a_d;
    t_flags             r_a_flags;

    logic [BLOCK_W-1:0] n_a_blk;
    logic [D_W-1:0]     n_a_d;
    t_flags             n_a_flags;

    always_comb begin
        n_a_flags.zero = (i_milli_hertz == '0);
        n_a_flags.fsat = !n_a_flags.zero &&
                         ((i_milli_hertz > TOP_MHZ) || (r_factor == '0));
        if (n_a_flags.fsat) begin
            n_a_blk = BLOCK_MAX;
        end else if (n_a_flags.zero) begin
            n_a_blk = '0;
        end else begin
            n_a_blk = pick_block(i_milli_hertz);
        end
        n_a_d = D_W'(r_factor) * D_W'(D_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_mhz   <= i_milli_hertz[MHZ_W-1:0];
            r_a_blk   <= n_a_blk;
            r_a_d     <= n_a_d;
            r_a_flags <= n_a_flags;
        end
    end

    // Stage B: numerators for the chosen block and for the next block up,
    // the fit limit 2048*d, and the divisor 2*d.
    logic [NUM_W-1:0]   r_b_num0;
    logic [NUM_W-1:0]   r_b_num1;
    logic [REM_W-1:0]   r_b_lim;
    logic [D2_W-1:0]    r_b_d2;
    logic [BLOCK_W-1:0] r_b_blk;
    t_flags             r_b_flags;

    logic [NUM_W-1:0] n_b_sh;

    assign n_b_sh = NUM_W'(r_a_mhz) << (SHIFT_BASE - SH_W'(r_a_blk));

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_num0  <= n_b_sh + NUM_W'(r_a_d);
            r_b_num1  <= (n_b_sh >> 1) + NUM_W'(r_a_d);
            r_b_lim   <= REM_W'(r_a_d) << LIM_SHIFT;
            r_b_d2    <= {r_a_d, 1'b0};
            r_b_blk   <= r_a_blk;
            r_b_flags <= r_a_flags;
        end
    end

    // Stage C: decide whether fnum fits, raise the block once if not,
    // and saturate when the block is already 7 or even that is not enough.
    logic [REM_W-1:0]   r_c_rem;
    logic [D2_W-1:0]    r_c_d2;
    logic [BLOCK_W-1:0] r_c_blk;
    t_flags             r_c_flags;

    logic [REM_W-1:0]   n_c_rem;
    logic [BLOCK_W-1:0] n_c_blk;
    t_flags             n_c_flags;

    always_comb begin
        n_c_rem   = r_b_num0[REM_W-1:0];
        n_c_blk   = r_b_blk;
        n_c_flags = r_b_flags;
        if (!r_b_flags.zero && !r_b_flags.fsat &&
            (r_b_num0 >= NUM_W'(r_b_lim))) begin
            if (r_b_blk == BLOCK_MAX) begin
                n_c_flags.fsat = 1'b1;
            end else begin
                n_c_blk        = r_b_blk + BLOCK_W'(1);
                n_c_rem        = r_b_num1[REM_W-1:0];
                n_c_flags.fsat = (r_b_num1 >= NUM_W'(r_b_lim));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c_rem   <= n_c_rem;
            r_c_d2    <= r_b_d2;
            r_c_blk   <= n_c_blk;
            r_c_flags <= n_c_flags;
        end
    end

    // Divider stages: each retires two quotient bits, most significant first.
    logic [REM_W-1:0]   r_rem   [DIV_STAGES];
    logic [D2_W-1:0]    r_d2    [DIV_STAGES];
    logic [FNUM_W-1:0]  r_q     [DIV_STAGES];
    logic [BLOCK_W-1:0] r_blk   [DIV_STAGES];
    t_flags             r_flags [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [REM_W-1:0]   s_rem_in;
        logic [D2_W-1:0]    s_d2_in;
        logic [FNUM_W-1:0]  s_q_in;
        logic [BLOCK_W-1:0] s_blk_in;
        t_flags             s_flags_in;
        logic [REM_W-1:0]   n_rem;
        logic [FNUM_W-1:0]  n_q;

        if (j == 0) begin : g_src_c
            assign s_rem_in   = r_c_rem;
            assign s_d2_in    = r_c_d2;
            assign s_q_in     = '0;
            assign s_blk_in   = r_c_blk;
            assign s_flags_in = r_c_flags;
        end else begin : g_src_div
            assign s_rem_in   = r_rem[j - 1];
            assign s_d2_in    = r_d2[j - 1];
            assign s_q_in     = r_q[j - 1];
            assign s_blk_in   = r_blk[j - 1];
            assign s_flags_in = r_flags[j - 1];
        end

        always_comb begin
            t_step st;
            n_rem = s_rem_in;
            n_q   = s_q_in;
            for (int s = 0; s < DIV_STEPS; s++) begin
                st    = div_step(n_rem, REM_W'(s_d2_in) <<
                                        (FNUM_W - 1 - (j * DIV_STEPS + s)));
                n_rem = st.rem;
                n_q   = {n_q[FNUM_W-2:0], st.qbit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[FRONT_STAGES + j]) begin
                r_rem[j]   <= n_rem;
                r_d2[j]    <= s_d2_in;
                r_q[j]     <= n_q;
                r_blk[j]   <= s_blk_in;
                r_flags[j] <= s_flags_in;
            end
        end
    end

    // Output: special cases override the quotient.
    assign o_out_valid = r_v[LAST];
    assign o_block_out = r_blk[DIV_STAGES - 1];
    assign o_fnum_out  = r_flags[DIV_STAGES - 1].zero ? '0 :
                         r_flags[DIV_STAGES - 1].fsat ? FNUM_MAX :
                         r_q[DIV_STAGES - 1];

endmodule

// File: rtl/ftfb_checker.sv
// Port-level checker for the frequency to fnum converter, with its bind.
`include "frequency_to_fnum_block_macros.svh"

module ftfb_checker
    import ftfb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [FNUM_W-1:0]   o_fnum_out,
    input logic [BLOCK_W-1:0]  o_block_out
);

    // A result that is not taken stays offered.
    `FTFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its payload.
    `FTFB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_fnum_out) && $stable(o_block_out))

    // Requests are refused only when the whole pipeline is full and blocked.
    `FTFB_ASSERT_NOW(a_backpressure, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // Any block above 0 holds a frequency large enough for a nonzero fnum.
    `FTFB_ASSERT_NOW(a_fnum_nonzero, i_clk, i_rst_n, o_out_valid && (o_block_out != '0), o_fnum_out != '0)

    // Reset empties the pipeline.
    `FTFB_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind frequency_to_fnum_block ftfb_checker u_ftfb_checker (.*);
